### rtl/mdru_pkg.sv
// Shared types and constants for the multiply/divide register unit.
`timescale 1ns / 1ps

package mdru_pkg;

  localparam logic [3:0] OFF_MUL_TRIG = 4'd5;
  localparam logic [3:0] OFF_DIV_TRIG = 4'd7;
  localparam logic [3:0] OFF_RES0     = 4'd8;
  localparam logic [3:0] OFF_RES1     = 4'd9;
  localparam logic [3:0] OFF_RES2     = 4'd10;
  localparam logic [3:0] OFF_RES3     = 4'd11;
  localparam logic [3:0] OFF_REM0     = 4'd12;
  localparam logic [3:0] OFF_REM1     = 4'd13;
  localparam logic [3:0] OFF_MODE     = 4'd14;
  localparam logic [3:0] OFF_STATUS   = 4'd15;

  localparam logic       REQ_WRITE    = 1'b1;
  localparam int         MODE_SIGNED  = 0;
  localparam logic [7:0] STATUS_DONE  = 8'h80;
  localparam int         DIV_STEPS    = 32;

  // controller -> datapath
  typedef struct packed {
    logic accept;    // input beat taken this cycle
    logic mul_go;    // form the product
    logic div_init;  // load magnitudes, catch divide by zero
    logic div_step;  // one restoring step
    logic div_fix;   // apply signs and store
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic dvs_zero;
  } sts_t;

endpackage

### rtl/mdru_ctrl.sv
// Sequencer for the multiply/divide register unit: handshakes and operation steps.
`timescale 1ns / 1ps

module mdru_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic          req_type,
  input  logic [3:0]    reg_offset,
  output logic          m_tvalid,
  input  logic          m_tready,
  output mdru_pkg::cmd_t cmd,
  input  mdru_pkg::sts_t sts
);
  import mdru_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DIV_INIT,
    S_DIV_RUN,
    S_DIV_FIX
  } state_t;

  localparam int CW = $clog2(DIV_STEPS);

  state_t        state;
  logic [CW-1:0] step;
  logic          accept;

  assign s_tready = (state == S_IDLE) && (!m_tvalid || m_tready);
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    cmd          = '0;
    cmd.accept   = accept;
    cmd.mul_go   = (state == S_MUL);
    cmd.div_init = (state == S_DIV_INIT);
    cmd.div_step = (state == S_DIV_RUN);
    cmd.div_fix  = (state == S_DIV_FIX);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      step     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // every beat answers with one byte, queued at accept
      if (accept) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept && req_type == REQ_WRITE) begin
            if (reg_offset == OFF_MUL_TRIG) begin
              state <= S_MUL;
            end else if (reg_offset == OFF_DIV_TRIG) begin
              state <= S_DIV_INIT;
            end
          end
        end
        S_MUL: begin
          state <= S_IDLE;
        end
        S_DIV_INIT: begin
          step  <= '0;
          state <= sts.dvs_zero ? S_IDLE : S_DIV_RUN;
        end
        S_DIV_RUN: begin
          step <= step + 1'b1;
          if (step == CW'(DIV_STEPS - 1)) begin
            state <= S_DIV_FIX;
          end
        end
        S_DIV_FIX: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/mdru_dp.sv
// Datapath for the multiply/divide register unit: register file, multiplier, divider.
`timescale 1ns / 1ps

module mdru_dp (
  input  logic           clk,
  input  logic           rst,
  input  mdru_pkg::cmd_t cmd,
  output mdru_pkg::sts_t sts,
  input  logic           req_type,
  input  logic [3:0]     reg_offset,
  input  logic [7:0]     write_data,
  output logic [7:0]     read_data
);
  import mdru_pkg::*;

  logic [7:0]  opnd [8];
  logic [7:0]  res  [4];
  logic [7:0]  remd [2];
  logic [7:0]  mode;
  logic        done;

  logic [31:0] dv_q;
  logic [15:0] dv_r;
  logic [15:0] dvs_mag;
  logic        neg_q;
  logic        neg_r;

  logic        sgn;
  logic [15:0] mcand, mplier, dvs;
  logic [31:0] dvd;
  logic [33:0] prod;
  logic [16:0] sh;
  logic        ge;
  logic [16:0] diff;
  logic [31:0] q_fix;
  logic [15:0] r_fix;
  logic [7:0]  rd_byte;
  logic        wr;

  assign sgn    = mode[MODE_SIGNED];
  assign mcand  = {opnd[1], opnd[0]};
  assign mplier = {opnd[5], opnd[4]};
  assign dvs    = {opnd[7], opnd[6]};
  assign dvd    = {opnd[3], opnd[2], opnd[1], opnd[0]};
  assign wr     = (req_type == REQ_WRITE);

  assign sts.dvs_zero = (dvs == '0);

  // 17-bit operands cover both modes: zero- or sign-extended
  assign prod = 34'($signed({sgn & mplier[15], mplier}) * $signed({sgn & mcand[15], mcand}));

  assign sh   = {dv_r, dv_q[31]};
  assign ge   = (sh >= {1'b0, dvs_mag});
  assign diff = sh - {1'b0, dvs_mag};

  assign q_fix = neg_q ? (32'd0 - dv_q) : dv_q;
  assign r_fix = neg_r ? (16'd0 - dv_r) : dv_r;

  always_comb begin
    rd_byte = '0;
    case (reg_offset)
      OFF_RES0:   rd_byte = res[0];
      OFF_RES1:   rd_byte = res[1];
      OFF_RES2:   rd_byte = res[2];
      OFF_RES3:   rd_byte = res[3];
      OFF_REM0:   rd_byte = remd[0];
      OFF_REM1:   rd_byte = remd[1];
      OFF_MODE:   rd_byte = mode;
      OFF_STATUS: rd_byte = done ? STATUS_DONE : 8'h00;
      default:    rd_byte = opnd[reg_offset[2:0]];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 8; i++) opnd[i] <= '0;
      for (int i = 0; i < 4; i++) res[i]  <= '0;
      for (int i = 0; i < 2; i++) remd[i] <= '0;
      mode <= '0;
      done <= 1'b0;
    end else begin
      if (cmd.accept) begin
        read_data <= wr ? 8'h00 : rd_byte;
        if (wr && !reg_offset[3]) begin
          opnd[reg_offset[2:0]] <= write_data;
        end else if (wr && reg_offset == OFF_MODE) begin
          for (int i = 0; i < 8; i++) opnd[i] <= '0;
          for (int i = 0; i < 4; i++) res[i]  <= '0;
          for (int i = 0; i < 2; i++) remd[i] <= '0;
          mode <= write_data;
        end else if (!wr && reg_offset == OFF_STATUS) begin
          done <= 1'b0;
        end
      end

      if (cmd.mul_go) begin
        for (int i = 0; i < 4; i++) res[i] <= prod[8*i +: 8];
        done <= 1'b1;
      end

      if (cmd.div_init) begin
        neg_q   <= sgn & (dvd[31] ^ dvs[15]);
        neg_r   <= sgn & dvd[31];
        dv_q    <= (sgn & dvd[31]) ? (32'd0 - dvd) : dvd;
        dvs_mag <= (sgn & dvs[15]) ? (16'd0 - dvs) : dvs;
        dv_r    <= '0;
        if (sts.dvs_zero) begin
          for (int i = 0; i < 4; i++) res[i] <= '0;
          remd[0] <= dvd[7:0];
          remd[1] <= dvd[15:8];
          done    <= 1'b1;
        end
      end

      if (cmd.div_step) begin
        dv_r <= ge ? diff[15:0] : sh[15:0];
        dv_q <= {dv_q[30:0], ge};
      end

      if (cmd.div_fix) begin
        for (int i = 0; i < 4; i++) res[i] <= q_fix[8*i +: 8];
        remd[0] <= r_fix[7:0];
        remd[1] <= r_fix[15:8];
        done    <= 1'b1;
      end
    end
  end

endmodule

### rtl/mul_div_register_unit.sv
// Top level of the byte-wide multiply/divide register unit.
`timescale 1ns / 1ps
//
// Register accesses arrive as beats on the s_ channel: tuser is the access kind
// (1 = write), tdata carries the offset and the write byte. Every beat returns
// one byte on the m_ channel: the register contents on a read, zero on a write.
// The answer is registered and shows up the cycle after the beat is taken.
// Writing offset 5 runs a 16x16 multiply in the S_MUL state.
// Writing offset 7 runs a 32/16 divide: a setup state, the radix-2 restoring
// divider loop and a sign-fixup state, in that order; a zero divisor ends the
// operation after the setup state. While an operation runs s_tready is low;
// other beats do not start an operation.
// A stalled answer holds in the output register; no new beat is taken until
// the output is free or drains in the same cycle.
// Synchronous reset clears all operand, result and mode bytes and the done
// flag, and drops m_tvalid.
module mul_div_register_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [3:0] reg_offset, [11:4] write_data, [15:12] zero
  input  logic        s_tuser,   // [0] req_type
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata    // [7:0] read_data
);
  import mdru_pkg::*;

  cmd_t cmd;
  sts_t sts;

  mdru_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .req_type   (s_tuser),
    .reg_offset (s_tdata[3:0]),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  mdru_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .req_type   (s_tuser),
    .reg_offset (s_tdata[3:0]),
    .write_data (s_tdata[11:4]),
    .read_data  (m_tdata)
  );

endmodule

### sim/tb_top.sv
// Self-checking testbench for the multiply/divide register unit.
`timescale 1ns / 1ps

module tb_top;
  import mdru_pkg::*;

  localparam logic       REQ_READ     = 1'b0;
  localparam logic [3:0] OFF_DVD0     = 4'd0;  // dividend bytes 0..3, multiplicand 0..1
  localparam logic [3:0] OFF_MPR_LO   = 4'd4;
  localparam logic [3:0] OFF_DVS_LO   = 4'd6;
  localparam int         N_RANDOM     = 900;
  localparam int         CYCLE_LIMIT  = 400000;
  localparam int         HOLDOFF_AT   = 300;
  localparam int         HOLDOFF_LEN  = 500;
  localparam int         DRAIN_CYCLES = 40;

  typedef struct {
    logic       wr;
    logic [3:0] off;
    logic [7:0] data;
  } access_t;

  typedef struct {
    logic [3:0] off;
    logic [7:0] rd;
  } read_back_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;  // [3:0] reg_offset, [11:4] write_data, [15:12] zero
  logic        s_tuser = 1'b0;  // [0] req_type
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;  // [7:0] read_data

  access_t     pending_access_q[$];
  read_back_t  expected_read_q[$];
  int          error_count = 0;
  int          beats_in = 0;
  int          cycle_cnt = 0;

  // predictor state
  bit [7:0]    oper_b[8];
  bit [7:0]    quot_prod_b[4];
  bit [7:0]    rem_b[2];
  bit [7:0]    mode_b;
  bit          done_b;

  mul_div_register_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  function automatic void store_quot_prod(bit [31:0] v);
    for (int i = 0; i < 4; i++) quot_prod_b[i] = v[8*i +: 8];
  endfunction

  // Applies one access to the predictor state and returns the byte read back.
  function automatic logic [7:0] predict_read_byte(access_t acc);
    bit [15:0] mcand, mplier, dvs, mag_s;
    bit [31:0] dvd, mag_d, q, r;
    bit        nd, ns;
    logic [7:0] rd;
    rd = 8'h00;
    if (acc.wr == REQ_WRITE) begin
      if (acc.off <= OFF_DIV_TRIG) begin
        oper_b[acc.off] = acc.data;
        mcand  = {oper_b[1], oper_b[0]};
        mplier = {oper_b[5], oper_b[4]};
        dvd    = {oper_b[3], oper_b[2], oper_b[1], oper_b[0]};
        dvs    = {oper_b[7], oper_b[6]};
        if (acc.off == OFF_MUL_TRIG) begin
          if (mode_b[MODE_SIGNED])
            store_quot_prod($signed({{16{mplier[15]}}, mplier}) *
                            $signed({{16{mcand[15]}}, mcand}));
          else
            store_quot_prod({16'h0, mplier} * {16'h0, mcand});
          done_b = 1'b1;
        end else if (acc.off == OFF_DIV_TRIG) begin
          if (dvs == 16'h0) begin
            q = 32'h0;
            r = {16'h0, dvd[15:0]};
          end else if (mode_b[MODE_SIGNED]) begin
            nd    = dvd[31];
            ns    = dvs[15];
            mag_d = nd ? 32'd0 - dvd : dvd;
            mag_s = ns ? 16'd0 - dvs : dvs;
            q = mag_d / {16'h0, mag_s};
            r = mag_d % {16'h0, mag_s};
            if (nd != ns) q = 32'd0 - q;
            if (nd) r = 32'd0 - r;
          end else begin
            q = dvd / {16'h0, dvs};
            r = dvd % {16'h0, dvs};
          end
          store_quot_prod(q);
          rem_b[0] = r[7:0];
          rem_b[1] = r[15:8];
          done_b = 1'b1;
        end
      end else if (acc.off == OFF_MODE) begin
        oper_b = '{default: 8'h00};
        quot_prod_b = '{default: 8'h00};
        rem_b = '{default: 8'h00};
        mode_b = acc.data;
      end
    end else begin
      if (acc.off <= OFF_DIV_TRIG)
        rd = oper_b[acc.off];
      else if (acc.off <= OFF_RES3)
        rd = quot_prod_b[acc.off - OFF_RES0];
      else if (acc.off <= OFF_REM1)
        rd = rem_b[acc.off - OFF_REM0];
      else if (acc.off == OFF_MODE)
        rd = mode_b;
      else if (done_b) begin
        done_b = 1'b0;
        rd = STATUS_DONE;
      end
    end
    return rd;
  endfunction

  // ---------------------------------------------------------------- stimulus

  task automatic push_access(logic wr, logic [3:0] off, logic [7:0] data);
    access_t acc;
    acc.wr = wr;
    acc.off = off;
    acc.data = data;
    pending_access_q.push_back(acc);
  endtask

  task automatic push_write16(logic [3:0] off, logic [15:0] v);
    push_access(REQ_WRITE, off, v[7:0]);
    push_access(REQ_WRITE, off + 4'd1, v[15:8]);
  endtask

  function automatic logic [15:0] pick16();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'h0001;
      2: return 16'h7FFF;
      3: return 16'h8000;
      4: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    int unsigned n_target, kind;
    bit is_div;

    // directed: signed overflow, divide by zero, largest signed square, ignored write
    push_access(REQ_READ, OFF_STATUS, 8'h00);
    push_access(REQ_WRITE, OFF_MODE, 8'h01);
    push_write16(OFF_DVD0, 16'h0000);
    push_write16(OFF_DVD0 + 4'd2, 16'h8000);
    push_write16(OFF_DVS_LO, 16'hFFFF);
    for (int i = 0; i < 6; i++) push_access(REQ_READ, OFF_RES0 + 4'(i), 8'h00);
    push_access(REQ_READ, OFF_STATUS, 8'h00);
    push_access(REQ_READ, OFF_STATUS, 8'h00);
    push_write16(OFF_DVS_LO, 16'h0000);
    push_access(REQ_READ, OFF_REM0, 8'h00);
    push_access(REQ_READ, OFF_REM1, 8'h00);
    push_access(REQ_WRITE, OFF_DVD0 + 4'd1, 8'h80);
    push_write16(OFF_MPR_LO, 16'h8000);
    push_access(REQ_READ, OFF_RES3, 8'h00);
    push_access(REQ_WRITE, OFF_RES1, 8'hFF);

    // random: mostly complete operations with polling, some noise
    n_target = pending_access_q.size() + N_RANDOM;
    while (pending_access_q.size() < n_target) begin
      kind = $urandom_range(0, 9);
      if (kind < 2) begin
        push_access(1'($urandom), 4'($urandom), 8'($urandom));
      end else if (kind == 2) begin
        push_access(REQ_WRITE, OFF_MODE, 8'($urandom));
        push_access(REQ_READ, OFF_MODE, 8'h00);
      end else begin
        if ($urandom_range(0, 3) == 0)
          push_access(REQ_WRITE, OFF_MODE, 8'($urandom));
        is_div = 1'($urandom);
        push_write16(OFF_DVD0, pick16());
        if (is_div) begin
          push_write16(OFF_DVD0 + 4'd2, pick16());
          push_write16(OFF_DVS_LO, pick16());
        end else begin
          push_write16(OFF_MPR_LO, pick16());
        end
        push_access(REQ_READ, OFF_STATUS, 8'h00);
        if ($urandom_range(0, 2) == 0) push_access(REQ_READ, OFF_STATUS, 8'h00);
        for (int i = 0; i < (is_div ? 6 : 4); i++)
          push_access(REQ_READ, OFF_RES0 + 4'(i), 8'h00);
      end
    end
  end

  // ------------------------------------------------------------------ driver

  access_t    drive_item;
  read_back_t exp_item;
  int         burst_left, gap_left;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      burst_left = 1;
      gap_left = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        exp_item.off = drive_item.off;
        exp_item.rd = predict_read_byte(drive_item);
        expected_read_q.push_back(exp_item);
        beats_in <= beats_in + 1;
      end
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (pending_access_q.size() > 0) begin
          drive_item = pending_access_q.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= {4'h0, drive_item.data, drive_item.off};
          s_tuser <= drive_item.wr;
          burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            gap_left = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 40) : 0;
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- receiver

  int  holdoff_left = 0;
  bit  holdoff_done = 1'b0;
  int  phase_left = 0;
  int  ready_mode = 0;

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (holdoff_left > 0) begin
      holdoff_left--;
      m_tready <= 1'b0;
    end else if (!holdoff_done && beats_in >= HOLDOFF_AT) begin
      // long back-pressure while the sender keeps offering beats
      holdoff_done = 1'b1;
      holdoff_left = HOLDOFF_LEN;
      m_tready <= 1'b0;
    end else begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(20, 200);
        ready_mode = $urandom_range(0, 3);
      end else begin
        phase_left--;
      end
      case (ready_mode)
        0: m_tready <= 1'b1;
        1: m_tready <= 1'($urandom);
        2: m_tready <= ($urandom_range(0, 7) != 0);
        default: m_tready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // ----------------------------------------------------------------- monitor

  read_back_t got_exp;

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_read_q.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("unexpected beat: read_data %02h", m_tdata);
      end else begin
        got_exp = expected_read_q.pop_front();
        if (m_tdata !== got_exp.rd) begin
          error_count++;
          if (error_count <= 10)
            $display("mismatch at offset %0d: read_data exp %02h got %02h",
                     got_exp.off, got_exp.rd, m_tdata);
        end
      end
    end
  end

  // ------------------------------------------------------------ run control

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    while (pending_access_q.size() > 0 || s_tvalid || expected_read_q.size() > 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (error_count == 0 && expected_read_q.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  initial begin
    wait (cycle_cnt == CYCLE_LIMIT);
    $display("timeout after %0d cycles", CYCLE_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

endmodule

### filelist.f
rtl/mdru_pkg.sv
rtl/mdru_ctrl.sv
rtl/mdru_dp.sv
rtl/mul_div_register_unit.sv
sim/tb_top.sv
